FILE: sv/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg - shared definitions for the line substring filter
// Sizes, register indexes and the line terminator code.
// ----------------------------------------------------------------------------
package lsf_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int LINE_LIMIT  = 256;
   localparam int COUNT_BITS  = 32;

   // line length saturates at LINE_LIMIT-1, so this many bits hold it
   localparam int LEN_BITS    = $clog2(LINE_LIMIT);
   localparam int USED_BITS   = $clog2(MAX_PATTERN + 1);
   localparam int PLEN_BITS   = 4;
   localparam int PAT_BITS    = 64;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [7:0]            byte_type;
   typedef logic [LEN_BITS-1:0]   length_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [USED_BITS-1:0]  used_type;

   localparam byte_type   NEWLINE_BYTE = 8'd10;
   localparam length_type LEN_MAX      = LEN_BITS'(LINE_LIMIT - 1);
   localparam count_type  COUNT_MAX    = '1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_BYTES  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT_SELECT  = 2'd2;

endpackage

FILE: sv/line_substring_filter.sv
// ----------------------------------------------------------------------------
// line_substring_filter - fixed-string line matcher on a byte stream
// Shifts each text byte into a short window, compares it with the pattern
// and gives one result per newline with line and match counts.
// ----------------------------------------------------------------------------
// A newline's result is registered at the clock edge that accepts the newline.
// Throughput: one byte per cycle; the window compare and counter updates
// are combinational between the state registers and the result register.
// A newline is held off only while the previous result is stalled.
// Reset (synchronous): clears control registers, result valid, window, flag, length and counts.
module line_substring_filter
   import lsf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_text_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_line_kept,
   output logic                    rsp_line_selected,
   output logic [31:0]             rsp_line_number,
   output logic [31:0]             rsp_match_total,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [PAT_BITS-1:0]     csr_data
);

   logic [PAT_BITS-1:0]  pattern_ff;
   logic [PLEN_BITS-1:0] plen_ff;
   logic                 invert_ff;

   byte_type   window_ff [MAX_PATTERN];
   byte_type   window_in [MAX_PATTERN];
   logic       found_ff,  found_in;
   length_type length_ff, length_in;
   count_type  kept_ff,   kept_in;
   count_type  sel_ff,    sel_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kept_ff, rsp_kept_in;
   logic       rsp_sel_ff, rsp_sel_in;
   count_type  rsp_num_ff, rsp_num_in;
   count_type  rsp_tot_ff, rsp_tot_in;

   logic       accept, is_newline, out_busy;
   used_type   used_len;
   logic [MAX_PATTERN:0] hit_by_len;
   logic       line_kept, line_hit, line_sel;

   assign csr_ready  = 1'b1;
   assign is_newline = (req_text_byte == NEWLINE_BYTE);
   assign out_busy   = rsp_valid_ff && rsp_stall;
   // only a newline needs the result slot
   assign req_stall  = out_busy && is_newline;
   assign accept     = req_valid && !req_stall;

   assign used_len = (32'(plen_ff) > MAX_PATTERN) ? USED_BITS'(MAX_PATTERN)
                                                  : USED_BITS'(plen_ff);

   always_comb begin
      for (int i = MAX_PATTERN - 1; i > 0; i--) begin
         window_in[i] = window_ff[i-1];
      end
      window_in[0] = req_text_byte;
      length_in = (length_ff < LEN_MAX) ? length_ff + 1'b1 : length_ff;
   end

   // hit_by_len[n]: the newest n window bytes equal the first n pattern bytes
   always_comb begin
      hit_by_len = '1;
      for (int n = 1; n <= MAX_PATTERN; n++) begin
         for (int i = 0; i < n; i++) begin
            if (window_in[n-1-i] != pattern_ff[8*i +: 8]) begin
               hit_by_len[n] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      found_in = found_ff || ((used_len != '0) &&
                  (32'(length_in) >= 32'(used_len)) && hit_by_len[used_len]);
      line_kept = (length_ff < LEN_MAX);
      line_hit  = (used_len == '0) || found_ff;
      line_sel  = line_kept && (invert_ff ? !line_hit : line_hit);
      kept_in   = kept_ff;
      sel_in    = sel_ff;
      if (line_kept && kept_ff != COUNT_MAX) begin
         kept_in = kept_ff + 1'b1;
      end
      if (line_sel && sel_ff != COUNT_MAX) begin
         sel_in = sel_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kept_in  = rsp_kept_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_tot_in   = rsp_tot_ff;
      if (accept && is_newline) begin
         rsp_valid_in = 1'b1;
         rsp_kept_in  = line_kept;
         rsp_sel_in   = line_sel;
         rsp_num_in   = kept_in;
         rsp_tot_in   = sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         plen_ff      <= '0;
         invert_ff    <= 1'b0;
         found_ff     <= 1'b0;
         length_ff    <= '0;
         kept_ff      <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PATTERN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PATTERN_BYTES:  pattern_ff <= csr_data;
               CSR_PATTERN_LENGTH: plen_ff    <= csr_data[PLEN_BITS-1:0];
               CSR_INVERT_SELECT:  invert_ff  <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            if (is_newline) begin
               found_ff  <= 1'b0;
               length_ff <= '0;
               kept_ff   <= kept_in;
               sel_ff    <= sel_in;
               for (int i = 0; i < MAX_PATTERN; i++) begin
                  window_ff[i] <= '0;
               end
            end else begin
               found_ff  <= found_in;
               length_ff <= length_in;
               window_ff <= window_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kept_ff <= rsp_kept_in;
      rsp_sel_ff  <= rsp_sel_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_tot_ff  <= rsp_tot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_kept     = rsp_kept_ff;
   assign rsp_line_selected = rsp_sel_ff;
   assign rsp_line_number   = 32'(rsp_num_ff);
   assign rsp_match_total   = 32'(rsp_tot_ff);

endmodule

FILE: sv/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker - port-level checks for the line substring filter
// Result timing against accepted bytes, and result field consistency.
// ----------------------------------------------------------------------------
module lsf_checker
   import lsf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_text_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_line_kept,
   input logic        rsp_line_selected,
   input logic [31:0] rsp_line_number
);

   // accepted newline always leaves a result behind
   a_newline_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_text_byte == NEWLINE_BYTE |=> rsp_valid)
      else $error("newline transaction gave no result");

   // an ordinary byte never creates a result
   a_byte_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_text_byte != NEWLINE_BYTE &&
      !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("result without newline");

   a_skip_not_selected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_kept |-> !rsp_line_selected)
      else $error("skipped line reported as selected");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_number))
      else $error("stalled result changed");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for line_substring_filter
// Streams text bytes through the filter and checks every line result
// against a local model of the window, match flag and counters. The tests
// cover directed patterns, long lines, register changes in the middle of a
// line, random text under several idle and stall mixes, and a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
   import lsf_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic        kept;
      logic        selected;
      logic [31:0] number;
      logic [31:0] total;
   } line_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_text_byte = 8'd0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_line_kept;
   logic                    rsp_line_selected;
   logic [31:0]             rsp_line_number;
   logic [31:0]             rsp_match_total;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [PAT_BITS-1:0]     csr_data = '0;

   line_substring_filter uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_kept     (rsp_line_kept),
      .rsp_line_selected (rsp_line_selected),
      .rsp_line_number   (rsp_line_number),
      .rsp_match_total   (rsp_match_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   // filter model: registers and per-line state
   logic [63:0]     cfg_pattern = '0;
   logic [3:0]      cfg_length  = '0;
   logic            cfg_invert  = 1'b0;
   logic [7:0]      text_window [MAX_PATTERN];
   logic            line_hit = 1'b0;
   int              open_len = 0;
   count_type       kept_lines = '0;
   count_type       selected_lines = '0;

   line_result_type expected_lines [$];
   int              errors = 0;
   int              bytes_sent = 0;
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              hold_requests = 0;
   int              hold_seen = 0;
   int              hold_left = 0;

   initial begin
      foreach (text_window[i]) text_window[i] = 8'd0;
   end

   // advance the model by one accepted byte, queue a result on newline
   task automatic model_text_byte(input logic [7:0] b);
      int              n;
      int              i;
      bit              hit;
      line_result_type r;
      n = (cfg_length > MAX_PATTERN) ? MAX_PATTERN : cfg_length;
      if (b != NEWLINE_BYTE) begin
         for (i = MAX_PATTERN - 1; i > 0; i--) text_window[i] = text_window[i-1];
         text_window[0] = b;
         if (open_len < LINE_LIMIT - 1) open_len++;
         if (n > 0 && open_len >= n) begin
            hit = 1'b1;
            for (i = 0; i < n; i++)
               if (text_window[n-1-i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
            if (hit) line_hit = 1'b1;
         end
      end else begin
         r.kept = (open_len < LINE_LIMIT - 1);
         r.selected = 1'b0;
         if (r.kept) begin
            hit = (n == 0) || line_hit;
            r.selected = cfg_invert ? !hit : hit;
            if (kept_lines != COUNT_MAX) kept_lines++;
            if (r.selected && selected_lines != COUNT_MAX) selected_lines++;
         end
         r.number = kept_lines[31:0];
         r.total = selected_lines[31:0];
         expected_lines.push_back(r);
         foreach (text_window[i]) text_window[i] = 8'd0;
         line_hit = 1'b0;
         open_len = 0;
      end
   endtask

   // offer one byte; valid stays high after acceptance until the next gap
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
      model_text_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [63:0] pack_pattern(input string s);
      logic [63:0] p;
      p = '0;
      for (int i = 0; i < s.len() && i < 8; i++) p[8*i +: 8] = s[i];
      return p;
   endfunction

   // stop sending and wait until every queued line result has come out
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN_BYTES:  cfg_pattern = value;
         CSR_PATTERN_LENGTH: cfg_length = value[3:0];
         CSR_INVERT_SELECT:  cfg_invert = value[0];
         default: ;
      endcase
   endtask

   task automatic set_filter(input logic [63:0] pat, input logic [3:0] len, input logic inv);
      drain_block();
      write_reg(CSR_PATTERN_BYTES, pat);
      write_reg(CSR_PATTERN_LENGTH, {60'd0, len});
      write_reg(CSR_INVERT_SELECT, {63'd0, inv});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] rand_text_byte();
      case ($urandom_range(9))
         0:       return 8'($urandom_range(255));
         1, 2, 3: return cfg_pattern[8*$urandom_range(7) +: 8];
         default: return 8'("a" + $urandom_range(3));
      endcase
   endfunction

   function automatic logic [63:0] rand_pattern();
      logic [63:0] p;
      for (int i = 0; i < 8; i++)
         p[8*i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'("a" + $urandom_range(2));
      return p;
   endfunction

   // mostly short lines seeded with full or partial copies of the pattern
   task automatic send_random_line();
      int len;
      int k;
      int n;
      int cut;
      if ($urandom_range(59) == 0) len = $urandom_range(LINE_LIMIT + 20, LINE_LIMIT - 3);
      else len = $urandom_range(16);
      n = (cfg_length > MAX_PATTERN) ? MAX_PATTERN : cfg_length;
      k = 0;
      while (k < len) begin
         if (n != 0 && $urandom_range(3) == 0) begin
            cut = ($urandom_range(2) == 0) ? $urandom_range(n, 1) : n;
            for (int i = 0; i < cut; i++) send_byte(cfg_pattern[8*i +: 8]);
            k += cut;
         end else begin
            send_byte(rand_text_byte());
            k++;
         end
      end
      // occasionally leave the line open so it runs into the next one
      if ($urandom_range(19) != 0) send_byte(NEWLINE_BYTE);
   endtask

   task automatic run_random_phase(input int idle, input int stall, input int nbytes);
      int start;
      int stop_at;
      idle_pct = idle;
      stall_pct = stall;
      start = bytes_sent;
      while (bytes_sent - start < nbytes) begin
         set_filter(rand_pattern(), 4'($urandom_range(15)), 1'($urandom_range(1)));
         stop_at = bytes_sent + 100;
         while (bytes_sent < stop_at) send_random_line();
      end
   endtask

   task automatic test_reset_defaults();
      // empty pattern selects every line, including an empty one
      send_text("a\n");
      send_text("\n");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(NEWLINE_BYTE);
   endtask

   task automatic test_directed_patterns();
      set_filter(pack_pattern("abc"), 4'd3, 1'b0);
      send_text("xabcx\n");
      send_text("ab\n");
      send_text("abc\n");
      set_filter(pack_pattern("ABCDEFGH"), 4'd8, 1'b0);
      send_text("ABCDEFGH\n");
      send_text("ABCDEFG\n");
      // lengths above the window size act as the full window
      set_filter(pack_pattern("ABCDEFGH"), 4'd15, 1'b0);
      send_text("zABCDEFGH\n");
      set_filter('1, 4'd8, 1'b1);
      repeat (8) send_byte(8'hFF);
      send_byte(NEWLINE_BYTE);
      send_byte(NEWLINE_BYTE);
      // zero bytes compare like any other byte
      set_filter('0, 4'd2, 1'b0);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(NEWLINE_BYTE);
      send_byte(8'h00);
      send_byte(NEWLINE_BYTE);
      drain_block();
      write_reg(CSR_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_text("q\n");
   endtask

   task automatic test_midline_registers();
      // invert is applied at the newline
      set_filter(pack_pattern("ab"), 4'd2, 1'b0);
      send_text("ab");
      set_filter(pack_pattern("ab"), 4'd2, 1'b1);
      send_byte(NEWLINE_BYTE);
      // the newline itself does not compare against a new pattern
      set_filter(pack_pattern("zz"), 4'd2, 1'b0);
      send_text("ab");
      set_filter(pack_pattern("ab"), 4'd2, 1'b0);
      send_text("\n");
   endtask

   task automatic test_long_lines();
      set_filter(pack_pattern("k"), 4'd1, 1'b0);
      repeat (LINE_LIMIT - 2) send_byte("k");
      send_byte(NEWLINE_BYTE);
      repeat (LINE_LIMIT - 1) send_byte("k");
      send_byte(NEWLINE_BYTE);
      repeat (LINE_LIMIT + 44) send_byte("k");
      send_byte(NEWLINE_BYTE);
      send_text("k\n");
   endtask

   task automatic test_random_text();
      run_random_phase(0, 0, 200);
      run_random_phase(60, 0, 200);
      run_random_phase(0, 60, 200);
      run_random_phase(33, 33, 200);
   endtask

   task automatic test_output_holdoff();
      set_filter(pack_pattern("b"), 4'd1, 1'b0);
      idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (30) send_text("ab\n");
      // sender waits here until the backlog is fully delivered
      drain_block();
   endtask

   task automatic test_trailing_bytes();
      idle_pct = 20;
      stall_pct = 20;
      send_text("unterminated");
      drain_block();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_patterns();
      test_midline_registers();
      test_long_lines();
      test_random_text();
      test_output_holdoff();
      test_trailing_bytes();
      repeat (4) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lines.size() == 0) begin
            $display("%0t: unexpected line result: expected none actual kept=%0b sel=%0b",
                     $time, rsp_line_kept, rsp_line_selected);
            errors++;
         end else begin
            want = expected_lines.pop_front();
            check_field("line_kept", 32'(want.kept), 32'(rsp_line_kept));
            check_field("line_selected", 32'(want.selected), 32'(rsp_line_selected));
            check_field("line_number", want.number, rsp_line_number);
            check_field("match_total", want.total, rsp_match_total);
         end
      end
   end

endmodule

FILE: line_substring_filter.f
sv/lsf_pkg.sv
sv/line_substring_filter.sv
sv/lsf_checker.sv
tb/tb_top.sv
